@@ src/clsp_pkg.sv @@
// shared types and constants of the command line segment splitter
// result codes, character codes and the record passed from parser to output stage
// no dependencies
package clsp_pkg;

    // most results one input byte can cause
    localparam int MaxRes = 3;
    localparam int CntW   = $clog2(MaxRes + 1);

    // unit step of a result count
    localparam logic [CntW-1:0] CntOne = CntW'(1);

    // result kinds
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_FNAME = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // redirect kinds
    localparam logic [1:0] RED_NONE   = 2'd0;
    localparam logic [1:0] RED_CREATE = 2'd1;
    localparam logic [1:0] RED_APPEND = 2'd2;

    // run conditions for the next segment
    localparam logic [1:0] COND_ALWAYS = 2'd0;
    localparam logic [1:0] COND_AND    = 2'd1;
    localparam logic [1:0] COND_OR     = 2'd2;

    // character codes
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // one result item, without the last-of-byte mark
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text_byte;
        logic [1:0] redirect;
        logic       pipe_out;
        logic [1:0] condition;
        logic       background;
        logic       local_path;
        logic       empty_segment;
    } t_result;

    // results of one byte, handed to the output stage
    typedef struct packed {
        logic                     load;
        logic [CntW-1:0]          cnt;
        t_result [MaxRes-1:0]     res;
    } t_bundle;

endpackage

@@ src/clsp_if.sv @@
// valid/ready channel interfaces for input bytes and result items
// depends on clsp_pkg for nothing but sits after it in compile order
interface clsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_line;

    modport source (output valid, output ch, output end_of_line, input ready);
    modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface clsp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] text_byte;
    logic [1:0] redirect;
    logic       pipe_out;
    logic [1:0] condition;
    logic       background;
    logic       local_path;
    logic       empty_segment;
    logic       run_last;

    modport source (output valid, output kind, output text_byte, output redirect,
                    output pipe_out, output condition, output background,
                    output local_path, output empty_segment, output run_last,
                    input ready);
    modport sink   (input valid, input kind, input text_byte, input redirect,
                    input pipe_out, input condition, input background,
                    input local_path, input empty_segment, input run_last,
                    output ready);
endinterface

@@ src/command_line_segment_splitter.sv @@
// Command line segment splitter, top level.
// An accepted byte waits in the input register until the result register has room.
// Throughput: one byte per cycle while each byte causes one result at most and o_out
//   is ready; a byte of up to three results holds the input register as they drain.
// Reset: synchronous, active low; clears the parse state to line start and empties
//   the input and result registers.
module command_line_segment_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clsp_in_if.sink     i_in,
    clsp_out_if.source  o_out
);

    clsp_pkg::t_bundle bundle;
    logic              load_ready;

    // byte parser with input register
    clsp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_load_ready (load_ready),
        .o_bundle     (bundle)
    );

    // result register and serializer
    clsp_drain u_drain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bundle     (bundle),
        .o_load_ready (load_ready),
        .o_out        (o_out)
    );

endmodule

@@ src/clsp_parser.sv @@
// input register, parse state and single-pass byte classification
// depends on clsp_pkg and clsp_in_if
module clsp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    clsp_in_if.sink             i_in,
    input  logic                i_load_ready,
    output clsp_pkg::t_bundle   o_bundle
);

    typedef enum logic [3:0] {
        M_LINE_START,
        M_TEXT,
        M_SEG_START,
        M_OP_SKIP,
        M_RED_SKIP,
        M_AFTER_PIPE,
        M_AFTER_AMP,
        M_AFTER_GT,
        M_FNAME_SKIP,
        M_FNAME,
        M_FNAME_SPACE
    } t_mode;

    typedef struct packed {
        logic [1:0] redirect;
        logic       pipe;
        logic [1:0] cond;
        logic       bg;
        logic       has_text;
        logic       loc;
        logic       decided;
    } t_seg;

    t_mode      r_mode, n_mode;
    t_seg       r_seg, n_seg;
    logic       r_quotes, n_quotes;
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_eol;
    logic       adv;

    logic [clsp_pkg::CntW-1:0]              n_cnt;
    clsp_pkg::t_result [clsp_pkg::MaxRes-1:0] n_res;

    // segment end record from the open segment
    function automatic clsp_pkg::t_result f_end(input t_seg s);
        clsp_pkg::t_result r;
        r               = '0;
        r.kind          = clsp_pkg::KIND_END;
        r.redirect      = s.redirect;
        r.pipe_out      = s.pipe;
        r.condition     = s.cond;
        r.background    = s.bg;
        r.local_path    = s.loc;
        r.empty_segment = ~s.has_text;
        return r;
    endfunction

    // text or file name byte record
    function automatic clsp_pkg::t_result f_byte(input logic [1:0] kind,
                                                 input logic [7:0] c);
        clsp_pkg::t_result r;
        r           = '0;
        r.kind      = kind;
        r.text_byte = c;
        return r;
    endfunction

    // input register frees when its byte moves to the output stage
    assign adv        = r_in_valid && i_load_ready;
    assign i_in.ready = !r_in_valid || adv;

    // one pass over the byte: mode steps run in the order they can chain
    always_comb begin
        t_mode      m;
        t_seg       s;
        logic       q;
        logic       done;
        logic       emit;
        logic       is_pipe;
        logic       is_quote;
        logic       lit_ops;
        logic       lit_semi;
        logic [7:0] c;
        logic [clsp_pkg::CntW-1:0] cnt;
        clsp_pkg::t_result [clsp_pkg::MaxRes-1:0] res;
        t_mode      next_m;

        c        = r_ch;
        m        = r_mode;
        s        = r_seg;
        q        = r_quotes;
        done     = 1'b0;
        emit     = 1'b0;
        cnt      = '0;
        res      = '0;
        is_pipe  = (m == M_AFTER_PIPE);
        is_quote = (c == clsp_pkg::CH_DQUOTE) || (c == clsp_pkg::CH_SQUOTE);
        lit_ops  = 1'b0;
        lit_semi = 1'b0;
        next_m   = M_OP_SKIP;

        // second > makes an append redirect
        if (m == M_AFTER_GT) begin
            m = M_FNAME_SKIP;
            if (c == clsp_pkg::CH_GT) begin
                s.redirect = clsp_pkg::RED_APPEND;
                done       = 1'b1;
            end
        end

        // spaces before the file name
        if (!done && m == M_FNAME_SKIP) begin
            if (c == clsp_pkg::CH_SPACE) begin
                done = 1'b1;
            end else begin
                m = M_FNAME;
            end
        end

        // file name bytes
        if (!done && m == M_FNAME) begin
            done = 1'b1;
            if (c == clsp_pkg::CH_SPACE) begin
                m = M_FNAME_SPACE;
            end else if (c == clsp_pkg::CH_SEMI) begin
                res[cnt] = f_end(s);
                cnt      = cnt + clsp_pkg::CntOne;
                s        = '0;
                m        = M_RED_SKIP;
            end else if (c == clsp_pkg::CH_PIPE) begin
                m = M_AFTER_PIPE;
            end else if (c == clsp_pkg::CH_AMP) begin
                m = M_AFTER_AMP;
            end else begin
                res[cnt] = f_byte(clsp_pkg::KIND_FNAME, c);
                cnt      = cnt + clsp_pkg::CntOne;
            end
        end

        // spaces after the file name
        if (!done && m == M_FNAME_SPACE) begin
            if (c == clsp_pkg::CH_SPACE) begin
                done = 1'b1;
            end else if (c == clsp_pkg::CH_PIPE) begin
                m    = M_AFTER_PIPE;
                done = 1'b1;
            end else if (c == clsp_pkg::CH_AMP) begin
                m    = M_AFTER_AMP;
                done = 1'b1;
            end else begin
                res[cnt] = f_end(s);
                cnt      = cnt + clsp_pkg::CntOne;
                s        = '0;
                m        = M_RED_SKIP;
                if (c == clsp_pkg::CH_SEMI) begin
                    done = 1'b1;
                end
            end
        end

        // byte after | or &: doubled operator or segment close
        if (!done && (m == M_AFTER_PIPE || m == M_AFTER_AMP)) begin
            is_pipe = (m == M_AFTER_PIPE);
            next_m  = (s.redirect != clsp_pkg::RED_NONE) ? M_RED_SKIP : M_OP_SKIP;
            if (c == (is_pipe ? clsp_pkg::CH_PIPE : clsp_pkg::CH_AMP)) begin
                s.cond = is_pipe ? clsp_pkg::COND_OR : clsp_pkg::COND_AND;
                done   = 1'b1;
            end else if (is_pipe) begin
                s.pipe = 1'b1;
            end else begin
                s.bg = 1'b1;
            end
            res[cnt] = f_end(s);
            cnt      = cnt + clsp_pkg::CntOne;
            s        = '0;
            m        = next_m;
        end

        // spaces after an operator
        if (!done && m == M_OP_SKIP) begin
            if (c == clsp_pkg::CH_SPACE) begin
                done = 1'b1;
            end else begin
                m = M_SEG_START;
            end
        end

        // spaces and semicolons after a redirect segment
        if (!done && m == M_RED_SKIP) begin
            if (c == clsp_pkg::CH_SPACE || c == clsp_pkg::CH_SEMI) begin
                done = 1'b1;
            end else begin
                m = M_SEG_START;
            end
        end

        // normal text, also for unused modes
        if (!done) begin
            lit_ops  = (m == M_SEG_START);
            lit_semi = lit_ops || (m == M_LINE_START);
            emit     = 1'b1;
            if (is_quote) begin
                q = ~q;
            end else if (!q) begin
                if (c == clsp_pkg::CH_SEMI && !lit_semi) begin
                    res[cnt] = f_end(s);
                    cnt      = cnt + clsp_pkg::CntOne;
                    s        = '0;
                    m        = M_SEG_START;
                    emit     = 1'b0;
                end else if (!lit_ops) begin
                    if (c == clsp_pkg::CH_PIPE) begin
                        m    = M_AFTER_PIPE;
                        emit = 1'b0;
                    end else if (c == clsp_pkg::CH_AMP) begin
                        m    = M_AFTER_AMP;
                        emit = 1'b0;
                    end else if (c == clsp_pkg::CH_GT) begin
                        s.redirect = clsp_pkg::RED_CREATE;
                        m          = M_AFTER_GT;
                        emit       = 1'b0;
                    end
                end
            end
            if (emit) begin
                if (!(c == clsp_pkg::CH_SPACE && !s.has_text)) begin
                    s.has_text = 1'b1;
                    if (!is_quote && !s.decided) begin
                        s.decided = 1'b1;
                        s.loc     = (c == clsp_pkg::CH_SLASH) || (c == clsp_pkg::CH_DOT);
                    end
                end
                res[cnt] = f_byte(clsp_pkg::KIND_TEXT, c);
                cnt      = cnt + clsp_pkg::CntOne;
                m        = M_TEXT;
            end
        end

        // end of line closes the segment and returns to line start
        if (r_eol) begin
            if (m == M_AFTER_PIPE) begin
                s.pipe = 1'b1;
            end else if (m == M_AFTER_AMP) begin
                s.bg = 1'b1;
            end
            res[cnt] = f_end(s);
            cnt      = cnt + clsp_pkg::CntOne;
            s        = '0;
            m        = M_LINE_START;
            q        = 1'b0;
        end

        n_mode   = m;
        n_seg    = s;
        n_quotes = q;
        n_cnt    = cnt;
        n_res    = res;
    end

    // results go to the output stage together with the state update
    always_comb begin
        o_bundle      = '0;
        o_bundle.load = adv;
        o_bundle.cnt  = n_cnt;
        o_bundle.res  = n_res;
    end

    // parse state and input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_LINE_START;
            r_seg      <= '0;
            r_quotes   <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_mode   <= n_mode;
                r_seg    <= n_seg;
                r_quotes <= n_quotes;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch  <= i_in.ch;
            r_eol <= i_in.end_of_line;
        end
    end

endmodule

@@ src/clsp_drain.sv @@
// result register: holds the results of one byte and hands them out one per cycle while o_out is ready
// depends on clsp_pkg and clsp_out_if
module clsp_drain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clsp_pkg::t_bundle   i_bundle,
    output logic                o_load_ready,
    clsp_out_if.source          o_out
);

    clsp_pkg::t_result [clsp_pkg::MaxRes-1:0] r_res, n_res;
    logic [clsp_pkg::CntW-1:0]                r_left, n_left;
    logic                                     take;

    // output transaction and room for the next byte's results
    assign take         = (r_left != '0) && o_out.ready;
    assign o_load_ready = (r_left == '0) || ((r_left == clsp_pkg::CntOne) && take);

    // load a new group or shift the taken result out
    always_comb begin
        n_left = r_left;
        n_res  = r_res;
        if (i_bundle.load) begin
            n_left = i_bundle.cnt;
            n_res  = i_bundle.res;
        end else if (take) begin
            n_left = r_left - clsp_pkg::CntOne;
            for (int k = 0; k < clsp_pkg::MaxRes - 1; k++) begin
                n_res[k] = r_res[k+1];
            end
        end
    end

    // count of results still waiting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // output drive
    assign o_out.valid         = (r_left != '0);
    assign o_out.kind          = r_res[0].kind;
    assign o_out.text_byte     = r_res[0].text_byte;
    assign o_out.redirect      = r_res[0].redirect;
    assign o_out.pipe_out      = r_res[0].pipe_out;
    assign o_out.condition     = r_res[0].condition;
    assign o_out.background    = r_res[0].background;
    assign o_out.local_path    = r_res[0].local_path;
    assign o_out.empty_segment = r_res[0].empty_segment;
    assign o_out.run_last      = (r_left == clsp_pkg::CntOne);

    // a byte's results never overwrite ones still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bundle.load |-> o_load_ready)
        else $error("result group loaded over waiting results");

    // byte results carry no segment flags
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.kind != clsp_pkg::KIND_END) |->
        (o_out.redirect == clsp_pkg::RED_NONE) && !o_out.pipe_out &&
        (o_out.condition == clsp_pkg::COND_ALWAYS) && !o_out.background &&
        !o_out.local_path && !o_out.empty_segment)
        else $error("segment flags set on a byte result");

    // a segment end carries a zero byte
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.kind == clsp_pkg::KIND_END) |-> (o_out.text_byte == 8'd0))
        else $error("segment end with nonzero byte");

    // a result that is not the last of its byte is followed by another
    a_group_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !o_out.run_last |=> o_out.valid)
        else $error("result group cut short");

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result pending after reset");

endmodule

@@ tb/clsp_split_check.sv @@
`timescale 1ns / 1ps
// result checker for the command line segment splitter testbench
// watches the byte and result channels, predicts results per byte and compares
// depends on clsp_pkg and the clsp_in_if / clsp_out_if interfaces
module clsp_split_check (
    input  logic i_clk,
    input  logic i_rst_n,
    clsp_in_if   i_in,
    clsp_out_if  i_out,
    output int   o_errors,
    output int   o_backlog
);

    // parser modes of the prediction
    typedef enum logic [3:0] {
        PM_LINE_START,
        PM_TEXT,
        PM_SEG_START,
        PM_OP_SKIP,
        PM_RED_SKIP,
        PM_AFTER_PIPE,
        PM_AFTER_AMP,
        PM_AFTER_GT,
        PM_FNAME_SKIP,
        PM_FNAME,
        PM_FNAME_SPACE
    } t_parse_mode;

    // one predicted result with its last-of-byte mark
    typedef struct packed {
        clsp_pkg::t_result res;
        logic              last;
    } t_split_item;

    t_split_item       expected_items[$];
    clsp_pkg::t_result byte_res [clsp_pkg::MaxRes];
    int                byte_cnt;
    int                errors = 0;

    // predicted parser state
    t_parse_mode mode;
    logic        quoted;
    logic [1:0]  red_kind;
    logic        pipe_pend;
    logic [1:0]  cond_pend;
    logic        bg_pend;
    logic        seg_text;
    logic        seg_local;
    logic        local_known;

    assign o_errors = errors;

    function automatic void clear_parse();
        mode        = PM_LINE_START;
        quoted      = 1'b0;
        red_kind    = clsp_pkg::RED_NONE;
        pipe_pend   = 1'b0;
        cond_pend   = clsp_pkg::COND_ALWAYS;
        bg_pend     = 1'b0;
        seg_text    = 1'b0;
        seg_local   = 1'b0;
        local_known = 1'b0;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [7:0] text, logic [1:0] red,
                                       logic pipe, logic [1:0] cond, logic bg, logic loc,
                                       logic empty);
        if (byte_cnt < clsp_pkg::MaxRes) begin
            byte_res[byte_cnt] = '{kind, text, red, pipe, cond, bg, loc, empty};
            byte_cnt++;
        end
    endfunction

    // command text byte, tracks emptiness and the local-path decision
    function automatic void pass_text(logic [7:0] c);
        logic quote;
        quote = (c == clsp_pkg::CH_DQUOTE) || (c == clsp_pkg::CH_SQUOTE);
        if (!(c == clsp_pkg::CH_SPACE && !seg_text)) begin
            seg_text = 1'b1;
            if (!quote && !local_known) begin
                local_known = 1'b1;
                seg_local   = (c == clsp_pkg::CH_SLASH) || (c == clsp_pkg::CH_DOT);
            end
        end
        add_result(clsp_pkg::KIND_TEXT, c, clsp_pkg::RED_NONE, 1'b0, clsp_pkg::COND_ALWAYS,
                   1'b0, 1'b0, 1'b0);
    endfunction

    // segment boundary with the pending flags, then a fresh segment
    function automatic void end_segment(t_parse_mode nxt);
        add_result(clsp_pkg::KIND_END, 8'h00, red_kind, pipe_pend, cond_pend, bg_pend,
                   seg_local, !seg_text);
        red_kind    = clsp_pkg::RED_NONE;
        pipe_pend   = 1'b0;
        cond_pend   = clsp_pkg::COND_ALWAYS;
        bg_pend     = 1'b0;
        seg_text    = 1'b0;
        seg_local   = 1'b0;
        local_known = 1'b0;
        mode        = nxt;
    endfunction

    // expected results of one accepted byte
    function automatic void split_byte(logic [7:0] c, logic eol);
        logic        again;
        logic        is_pipe;
        logic        lit_ops;
        logic        lit_semi;
        logic [7:0]  op;
        t_parse_mode nxt;
        byte_cnt = 0;
        again    = 1'b1;
        while (again) begin
            again = 1'b0;
            case (mode)
                PM_OP_SKIP: begin
                    if (c != clsp_pkg::CH_SPACE) begin
                        mode  = PM_SEG_START;
                        again = 1'b1;
                    end
                end
                PM_RED_SKIP: begin
                    if (c != clsp_pkg::CH_SPACE && c != clsp_pkg::CH_SEMI) begin
                        mode  = PM_SEG_START;
                        again = 1'b1;
                    end
                end
                PM_AFTER_PIPE, PM_AFTER_AMP: begin
                    is_pipe = (mode == PM_AFTER_PIPE);
                    op      = is_pipe ? clsp_pkg::CH_PIPE : clsp_pkg::CH_AMP;
                    nxt     = (red_kind != clsp_pkg::RED_NONE) ? PM_RED_SKIP : PM_OP_SKIP;
                    if (c == op) begin
                        cond_pend = is_pipe ? clsp_pkg::COND_OR : clsp_pkg::COND_AND;
                        end_segment(nxt);
                    end else begin
                        if (is_pipe)
                            pipe_pend = 1'b1;
                        else
                            bg_pend = 1'b1;
                        end_segment(nxt);
                        again = 1'b1;
                    end
                end
                PM_AFTER_GT: begin
                    mode = PM_FNAME_SKIP;
                    if (c == clsp_pkg::CH_GT)
                        red_kind = clsp_pkg::RED_APPEND;
                    else
                        again = 1'b1;
                end
                PM_FNAME_SKIP: begin
                    if (c != clsp_pkg::CH_SPACE) begin
                        mode  = PM_FNAME;
                        again = 1'b1;
                    end
                end
                PM_FNAME: begin
                    if (c == clsp_pkg::CH_SPACE)
                        mode = PM_FNAME_SPACE;
                    else if (c == clsp_pkg::CH_SEMI)
                        end_segment(PM_RED_SKIP);
                    else if (c == clsp_pkg::CH_PIPE)
                        mode = PM_AFTER_PIPE;
                    else if (c == clsp_pkg::CH_AMP)
                        mode = PM_AFTER_AMP;
                    else
                        add_result(clsp_pkg::KIND_FNAME, c, clsp_pkg::RED_NONE, 1'b0,
                                   clsp_pkg::COND_ALWAYS, 1'b0, 1'b0, 1'b0);
                end
                PM_FNAME_SPACE: begin
                    if (c == clsp_pkg::CH_PIPE) begin
                        mode = PM_AFTER_PIPE;
                    end else if (c == clsp_pkg::CH_AMP) begin
                        mode = PM_AFTER_AMP;
                    end else if (c != clsp_pkg::CH_SPACE) begin
                        // any other byte ends the redirect segment and, unless it is a semicolon, is kept
                        end_segment(PM_RED_SKIP);
                        again = (c != clsp_pkg::CH_SEMI);
                    end
                end
                default: begin
                    lit_ops  = (mode == PM_SEG_START);
                    lit_semi = lit_ops || (mode == PM_LINE_START);
                    if (c == clsp_pkg::CH_DQUOTE || c == clsp_pkg::CH_SQUOTE) begin
                        quoted = !quoted;
                        pass_text(c);
                        mode = PM_TEXT;
                    end else if (!quoted && c == clsp_pkg::CH_SEMI && !lit_semi) begin
                        end_segment(PM_SEG_START);
                    end else if (!quoted && !lit_ops && c == clsp_pkg::CH_PIPE) begin
                        mode = PM_AFTER_PIPE;
                    end else if (!quoted && !lit_ops && c == clsp_pkg::CH_AMP) begin
                        mode = PM_AFTER_AMP;
                    end else if (!quoted && !lit_ops && c == clsp_pkg::CH_GT) begin
                        red_kind = clsp_pkg::RED_CREATE;
                        mode     = PM_AFTER_GT;
                    end else begin
                        pass_text(c);
                        mode = PM_TEXT;
                    end
                end
            endcase
        end
        // end of line closes the open segment and clears everything
        if (eol) begin
            if (mode == PM_AFTER_PIPE)
                pipe_pend = 1'b1;
            else if (mode == PM_AFTER_AMP)
                bg_pend = 1'b1;
            end_segment(PM_LINE_START);
            clear_parse();
        end
        for (int i = 0; i < byte_cnt; i++)
            expected_items.push_back('{byte_res[i], i == byte_cnt - 1});
    endfunction

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_split_item want;
        if (!i_rst_n) begin
            clear_parse();
            expected_items.delete();
        end else begin
            // compare a result transaction with the oldest prediction
            if (i_out.valid && i_out.ready) begin
                if (expected_items.size() == 0) begin
                    $error("result transaction with nothing expected, kind %0d", i_out.kind);
                    errors++;
                end else begin
                    want = expected_items.pop_front();
                    check_field("kind", 8'(want.res.kind), 8'(i_out.kind));
                    check_field("text_byte", want.res.text_byte, i_out.text_byte);
                    check_field("redirect", 8'(want.res.redirect), 8'(i_out.redirect));
                    check_field("pipe_out", 8'(want.res.pipe_out), 8'(i_out.pipe_out));
                    check_field("condition", 8'(want.res.condition), 8'(i_out.condition));
                    check_field("background", 8'(want.res.background),
                                8'(i_out.background));
                    check_field("local_path", 8'(want.res.local_path),
                                8'(i_out.local_path));
                    check_field("empty_segment", 8'(want.res.empty_segment),
                                8'(i_out.empty_segment));
                    check_field("run_last", 8'(want.last), 8'(i_out.run_last));
                end
            end
            // predict the results of an accepted byte
            if (i_in.valid && i_in.ready)
                split_byte(i_in.ch, i_in.end_of_line);
        end
        o_backlog <= expected_items.size();
    end

endmodule

@@ tb/tb_command_line_segment_splitter.sv @@
`timescale 1ns / 1ps
// testbench top for the command line segment splitter: clock, reset, byte and ready stimulus
// depends on clsp_pkg, the channel interfaces, the block and clsp_split_check
module tb_command_line_segment_splitter;

    localparam int StallLimit = 2000;
    localparam int HoldCycles = 150;
    localparam int TailCycles = 10;
    localparam int PhaseBytes = 110;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_request  = 1'b0;
    bit   hold_done     = 1'b0;
    int   bytes_sent    = 0;
    int   no_accept_cycles = 0;
    int   errors;
    int   backlog;
    logic [7:0] line_bytes[$];

    clsp_in_if  in_bus ();
    clsp_out_if out_bus ();

    command_line_segment_splitter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    clsp_split_check u_split_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_bus),
        .i_out     (out_bus),
        .o_errors  (errors),
        .o_backlog (backlog)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                no_accept_cycles <= 0;
            else
                no_accept_cycles <= no_accept_cycles + 1;
            if (no_accept_cycles >= StallLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side: random stalls and one long hold-off on request
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // offer one byte, with random gaps before it, and wait for its transaction
    task automatic send_byte(input logic [7:0] c, input logic eol);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.ch          <= c;
        in_bus.end_of_line <= eol;
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit eol_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eol_last && (i == s.len() - 1));
    endtask

    // plain word, now and then with a quote inside
    function automatic void push_word();
        string alpha;
        int    n;
        alpha = "abqz/.-_09";
        n = $urandom_range(1, 5);
        repeat (n) begin
            if ($urandom_range(0, 29) == 0)
                line_bytes.push_back($urandom_range(0, 1) ? clsp_pkg::CH_DQUOTE
                                                          : clsp_pkg::CH_SQUOTE);
            else
                line_bytes.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
        end
    endfunction

    // random command line built mostly from well-formed tokens
    function automatic void build_line();
        int tokens;
        int pick;
        line_bytes.delete();
        tokens = $urandom_range(1, 8);
        repeat (tokens) begin
            pick = $urandom_range(0, 99);
            if (pick < 36) begin
                push_word();
            end else if (pick < 52) begin
                repeat ($urandom_range(1, 3)) line_bytes.push_back(clsp_pkg::CH_SPACE);
            end else if (pick < 60) begin
                line_bytes.push_back(clsp_pkg::CH_SEMI);
            end else if (pick < 68) begin
                line_bytes.push_back(clsp_pkg::CH_PIPE);
                if ($urandom_range(0, 1))
                    line_bytes.push_back(clsp_pkg::CH_PIPE);
            end else if (pick < 76) begin
                line_bytes.push_back(clsp_pkg::CH_AMP);
                if ($urandom_range(0, 1))
                    line_bytes.push_back(clsp_pkg::CH_AMP);
            end else if (pick < 88) begin
                // redirect with file name
                line_bytes.push_back(clsp_pkg::CH_GT);
                if ($urandom_range(0, 1))
                    line_bytes.push_back(clsp_pkg::CH_GT);
                repeat ($urandom_range(0, 2)) line_bytes.push_back(clsp_pkg::CH_SPACE);
                push_word();
            end else if (pick < 93) begin
                line_bytes.push_back($urandom_range(0, 1) ? clsp_pkg::CH_DQUOTE
                                                          : clsp_pkg::CH_SQUOTE);
            end else begin
                line_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // stimulus and verdict
    initial begin
        int target;
        in_bus.valid       <= 1'b0;
        in_bus.ch          <= 8'h00;
        in_bus.end_of_line <= 1'b0;
        i_rst_n            <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        send_text(";;;", 1'b1);
        send_byte(8'h00, 1'b0);
        send_text(" a>b c&&d", 1'b1);
        send_text("\"|'>>'x|y", 1'b1);
        send_text("./p||", 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("a&", 1'b1);

        // random lines under three idling schemes
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 46;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = bytes_sent + PhaseBytes;
            while (bytes_sent < target) begin
                // one long receiver hold-off while bytes keep coming
                if (ph == 0 && bytes_sent >= 70 && !hold_done) begin
                    hold_request = 1'b1;
                    hold_done    = 1'b1;
                end
                build_line();
                foreach (line_bytes[i])
                    send_byte(line_bytes[i], i == line_bytes.size() - 1);
            end
        end
        in_bus.valid <= 1'b0;

        // drain the outstanding results
        @(posedge i_clk);
        while (backlog != 0)
            @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
        if (errors == 0 && backlog == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
